// ===== rtl/jssp_pkg.sv =====
`default_nettype none
package jssp_pkg;

	localparam int AXES_DEF  = 6;
	localparam int QDEPTH    = 2;
	localparam int DIV_STEPS = 64;

	localparam logic [30:0] MIN_DUR = 31'd328;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_INVALID   = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;
	localparam logic [1:0] ST_NOT_READY = 2'd3;

	typedef enum logic [1:0] {
		K_LOAD,
		K_START,
		K_STEP,
		K_BAD
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [2:0]         axis;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic [30:0]        accel_limit;
		logic signed [31:0] pos_min;
		logic signed [31:0] pos_max;
		logic [30:0]        dt;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  axis_out;
		logic [31:0] position_out;
		logic [31:0] velocity_out;
		logic [31:0] accel_out;
		logic [1:0]  vector_status;
		logic        last;
		logic        still_active;
	} res_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DECODE,
		B_CHK,
		B_RDIV,
		B_RWAIT,
		B_EMUL,
		B_ECHK,
		B_UDIV,
		B_UWAIT,
		B_MUL,
		B_MWB,
		B_ADIV,
		B_AWAIT,
		B_EMIT
	} bstate_t;

endpackage
`default_nettype wire

// ===== rtl/jssp_front.sv =====
`default_nettype none
module jssp_front #(
	parameter int AXES = jssp_pkg::AXES_DEF
) (
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic [2:0]         axis,
	input  wire logic signed [31:0] position,
	input  wire logic signed [31:0] velocity,
	input  wire logic [30:0]        accel_limit,
	input  wire logic signed [31:0] pos_min,
	input  wire logic signed [31:0] pos_max,
	input  wire logic [30:0]        dt,
	input  wire logic               q_full,
	output logic                    q_push,
	output jssp_pkg::cmd_t          q_cmd
);

	logic axis_ok;

	assign axis_ok  = {2'b00, axis} < 5'(AXES);
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_cmd.axis        = axis;
		q_cmd.position    = position;
		q_cmd.velocity    = velocity;
		q_cmd.accel_limit = accel_limit;
		q_cmd.pos_min     = pos_min;
		q_cmd.pos_max     = pos_max;
		q_cmd.dt          = dt;
		unique case (op)
			jssp_pkg::OP_LOAD: begin
				q_cmd.kind = axis_ok ? jssp_pkg::K_LOAD : jssp_pkg::K_BAD;
			end
			jssp_pkg::OP_START: begin
				q_cmd.kind = jssp_pkg::K_START;
			end
			jssp_pkg::OP_STEP: begin
				q_cmd.kind = jssp_pkg::K_STEP;
			end
			default: begin
				q_cmd.kind = jssp_pkg::K_BAD;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/jssp_fifo.sv =====
`default_nettype none
module jssp_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire jssp_pkg::cmd_t wr_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                empty,
	output jssp_pkg::cmd_t      rd_cmd
);

	localparam int PW = (jssp_pkg::QDEPTH > 1) ? $clog2(jssp_pkg::QDEPTH) : 1;
	localparam int CW = $clog2(jssp_pkg::QDEPTH + 1);

	jssp_pkg::cmd_t mem_q [jssp_pkg::QDEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;
	logic           do_push;
	logic           do_pop;

	assign full    = cnt_q == CW'(jssp_pkg::QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(jssp_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(jssp_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wr_cmd;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/jssp_div.sv =====
`default_nettype none
module jssp_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [47:0] divisor,
	output logic             busy,
	output logic [63:0]      quotient
);

	logic [6:0]  cnt_q;
	logic        busy_q;
	logic [63:0] quo_q;
	logic [47:0] rem_q;
	logic [47:0] dvs_q;
	logic [48:0] rem_sh;
	logic [48:0] diff;
	logic        take;

	// restoring, one quotient bit a cycle
	assign rem_sh   = {rem_q, quo_q[63]};
	assign diff     = rem_sh - {1'b0, dvs_q};
	assign take     = rem_sh >= {1'b0, dvs_q};
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'(jssp_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[47:0] : rem_sh[47:0];
			quo_q <= {quo_q[62:0], take};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/jssp_back.sv =====
`default_nettype none
module jssp_back #(
	parameter int AXES = jssp_pkg::AXES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_empty,
	input  wire jssp_pkg::cmd_t q_cmd,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output jssp_pkg::res_t      res
);

	localparam int IW = (AXES > 1) ? $clog2(AXES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(AXES - 1);

	localparam logic [3:0] M_U2  = 4'd0;
	localparam logic [3:0] M_U3  = 4'd1;
	localparam logic [3:0] M_U4  = 4'd2;
	localparam logic [3:0] M_W2  = 4'd3;
	localparam logic [3:0] M_V   = 4'd4;
	localparam logic [3:0] M_UW  = 4'd5;
	localparam logic [3:0] M_T   = 4'd6;
	localparam logic [3:0] M_OHI = 4'd7;
	localparam logic [3:0] M_OLO = 4'd8;
	localparam logic [3:0] M_VEL = 4'd9;
	localparam logic [3:0] M_ACC = 4'd10;

	function automatic logic [63:0] sx64(input logic [31:0] x);
		return {{32{x[31]}}, x};
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (32'd0 - x) : x;
	endfunction

	function automatic logic [31:0] sat_s64(input logic [63:0] x);
		logic [31:0] r;
		if ($signed(x) > 64'sh7FFF_FFFF) begin
			r = 32'h7FFF_FFFF;
		end else if ($signed(x) < -64'sh8000_0000) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] sat_mag(input logic [63:0] m, input logic neg);
		logic [31:0] r;
		if (neg) begin
			r = (m >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
		end else begin
			r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		end
		return r;
	endfunction

	jssp_pkg::bstate_t state_q, state_d;

	// staged and committed per-axis state
	logic signed [31:0] stg_pos_q [AXES];
	logic signed [31:0] stg_vel_q [AXES];
	logic [30:0]        stg_acc_q [AXES];
	logic signed [31:0] stg_min_q [AXES];
	logic signed [31:0] stg_max_q [AXES];
	logic signed [31:0] act_pos_q [AXES];
	logic signed [31:0] act_vel_q [AXES];
	logic signed [31:0] act_min_q [AXES];
	logic signed [31:0] act_max_q [AXES];

	logic [30:0] dur_q;
	logic [30:0] elapsed_q;
	logic        running_q;

	logic [IW-1:0]  idx_q;
	logic [3:0]     mstep_q;
	logic [1:0]     st_q;
	logic           single_q;
	logic           any_out_q;
	logic           out_valid_q;
	jssp_pkg::res_t res_q;
	jssp_pkg::cmd_t cmd_q;

	logic [30:0] dacc_q;
	logic [30:0] u_q, u2_q, u3_q, u4_q, w_q, w2_q, v_q, uw_q, p_q;
	logic [47:0] t_q;
	logic [63:0] off_q;
	logic [33:0] vmag_q;
	logic [63:0] pos_q;
	logic [63:0] adv_q;
	logic [63:0] amag_q;
	logic [63:0] prod_q;

	logic [31:0]    mul_a, mul_b;
	logic           div_start, div_busy;
	logic [63:0]    div_dvd, div_quo;
	logic [47:0]    div_dvs;
	logic           is_last, slot_free;
	logic [3:0]     ax4;
	logic [IW-1:0]  ld_idx;
	logic [31:0]    stg_av, act_av;
	logic           stg_neg, act_neg;
	logic           chk_fail;
	logic [33:0]    tri_av;
	logic [30:0]    ratio;
	logic [63:0]    end_off, end_pos;
	logic           end_ok;
	logic [31:0]    e_sum;
	logic [30:0]    e_clamp;
	logic           pos_ok;
	jssp_pkg::res_t res_d;

	jssp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign is_last   = idx_q == LAST_IDX;
	assign slot_free = !out_valid_q || out_ready;
	assign ax4       = 4'(idx_q);
	assign ld_idx    = IW'({1'b0, cmd_q.axis});
	assign stg_av    = mag32(stg_vel_q[idx_q]);
	assign stg_neg   = stg_vel_q[idx_q][31];
	assign act_av    = mag32(act_vel_q[idx_q]);
	assign act_neg   = act_vel_q[idx_q][31];
	assign chk_fail  = (stg_acc_q[idx_q] == '0) || (stg_pos_q[idx_q] < stg_min_q[idx_q])
		|| (stg_pos_q[idx_q] > stg_max_q[idx_q]);
	assign tri_av    = {1'b0, stg_av, 1'b0} + {2'b00, stg_av};
	assign ratio     = (div_quo > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : div_quo[30:0];
	assign end_off   = {17'd0, prod_q[63:17]};
	assign end_pos   = sx64(stg_pos_q[idx_q]) + (stg_neg ? (64'd0 - end_off) : end_off);
	assign end_ok    = ($signed(end_pos) >= $signed(sx64(stg_min_q[idx_q])))
		&& ($signed(end_pos) <= $signed(sx64(stg_max_q[idx_q])));
	assign e_sum     = {1'b0, elapsed_q} + {1'b0, cmd_q.dt};
	assign e_clamp   = (e_sum > {1'b0, dur_q}) ? dur_q : e_sum[30:0];
	assign pos_ok    = ($signed(pos_q) >= $signed(sx64(act_min_q[idx_q])))
		&& ($signed(pos_q) <= $signed(sx64(act_max_q[idx_q])));
	assign out_valid = out_valid_q;
	assign res       = res_q;

	// divider operands
	always_comb begin
		unique case (state_q)
			jssp_pkg::B_RDIV: begin
				div_dvd = {14'd0, tri_av, 16'd0};
				div_dvs = {16'd0, stg_acc_q[idx_q], 1'b0};
			end
			jssp_pkg::B_UDIV: begin
				div_dvd = {3'd0, elapsed_q, 30'd0};
				div_dvs = {17'd0, dur_q};
			end
			jssp_pkg::B_ADIV: begin
				div_dvd = adv_q;
				div_dvs = {3'd0, dur_q, 14'd0};
			end
			default: begin
				div_dvd = '0;
				div_dvs = '0;
			end
		endcase
	end

	// multiplier operands
	always_comb begin
		if (state_q == jssp_pkg::B_EMUL) begin
			mul_a = stg_av;
			mul_b = {1'b0, dacc_q};
		end else begin
			unique case (mstep_q)
				M_U2:    begin mul_a = {1'b0, u_q};  mul_b = {1'b0, u_q}; end
				M_U3:    begin mul_a = {1'b0, u2_q}; mul_b = {1'b0, u_q}; end
				M_U4:    begin mul_a = {1'b0, u3_q}; mul_b = {1'b0, u_q}; end
				M_W2:    begin mul_a = {1'b0, w_q};  mul_b = {1'b0, w_q}; end
				M_V: begin
					mul_a = {1'b0, w2_q};
					mul_b = {1'b0, jssp_pkg::ONE_Q30} + {u_q, 1'b0};
				end
				M_UW:    begin mul_a = {1'b0, u_q};  mul_b = {1'b0, w_q}; end
				M_T:     begin mul_a = act_av; mul_b = {1'b0, dur_q}; end
				M_OHI:   begin mul_a = {14'd0, t_q[47:30]}; mul_b = {1'b0, p_q}; end
				M_OLO:   begin mul_a = {2'd0, t_q[29:0]};   mul_b = {1'b0, p_q}; end
				M_VEL:   begin mul_a = act_av; mul_b = {1'b0, v_q}; end
				M_ACC:   begin mul_a = act_av; mul_b = {1'b0, uw_q}; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	// result of the current transfer
	always_comb begin
		if (single_q) begin
			res_d.status        = st_q;
			res_d.axis_out      = '0;
			res_d.position_out  = '0;
			res_d.velocity_out  = '0;
			res_d.accel_out     = '0;
			res_d.vector_status = jssp_pkg::ST_OK;
			res_d.last          = 1'b1;
		end else begin
			res_d.status        = pos_ok ? jssp_pkg::ST_OK : jssp_pkg::ST_LIMIT;
			res_d.axis_out      = ax4[2:0];
			res_d.position_out  = sat_s64(pos_q);
			res_d.velocity_out  = sat_mag({30'd0, vmag_q}, act_neg);
			res_d.accel_out     = sat_mag(amag_q, !act_neg);
			res_d.vector_status = (is_last && (any_out_q || !pos_ok)) ?
				jssp_pkg::ST_LIMIT : jssp_pkg::ST_OK;
			res_d.last          = is_last;
		end
		res_d.still_active = running_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jssp_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			jssp_pkg::B_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = jssp_pkg::B_DECODE;
				end
			end
			jssp_pkg::B_DECODE: begin
				unique case (cmd_q.kind)
					jssp_pkg::K_LOAD, jssp_pkg::K_BAD: state_d = jssp_pkg::B_EMIT;
					jssp_pkg::K_START: state_d = jssp_pkg::B_CHK;
					jssp_pkg::K_STEP: begin
						state_d = running_q ? jssp_pkg::B_UDIV : jssp_pkg::B_EMIT;
					end
				endcase
			end
			jssp_pkg::B_CHK: begin
				if (chk_fail) begin
					state_d = jssp_pkg::B_EMIT;
				end else if (is_last) begin
					state_d = jssp_pkg::B_RDIV;
				end
			end
			jssp_pkg::B_RDIV: begin
				div_start = 1'b1;
				state_d   = jssp_pkg::B_RWAIT;
			end
			jssp_pkg::B_RWAIT: begin
				if (!div_busy) begin
					state_d = is_last ? jssp_pkg::B_EMUL : jssp_pkg::B_RDIV;
				end
			end
			jssp_pkg::B_EMUL: begin
				state_d = jssp_pkg::B_ECHK;
			end
			jssp_pkg::B_ECHK: begin
				state_d = (!end_ok || is_last) ? jssp_pkg::B_EMIT : jssp_pkg::B_EMUL;
			end
			jssp_pkg::B_UDIV: begin
				div_start = 1'b1;
				state_d   = jssp_pkg::B_UWAIT;
			end
			jssp_pkg::B_UWAIT: begin
				if (!div_busy) begin
					state_d = jssp_pkg::B_MUL;
				end
			end
			jssp_pkg::B_MUL: begin
				state_d = jssp_pkg::B_MWB;
			end
			jssp_pkg::B_MWB: begin
				state_d = (mstep_q == M_ACC) ? jssp_pkg::B_ADIV : jssp_pkg::B_MUL;
			end
			jssp_pkg::B_ADIV: begin
				div_start = 1'b1;
				state_d   = jssp_pkg::B_AWAIT;
			end
			jssp_pkg::B_AWAIT: begin
				if (!div_busy) begin
					state_d = jssp_pkg::B_EMIT;
				end
			end
			jssp_pkg::B_EMIT: begin
				if (slot_free) begin
					state_d = (single_q || is_last) ? jssp_pkg::B_IDLE : jssp_pkg::B_MUL;
				end
			end
			default: begin
				state_d = jssp_pkg::B_IDLE;
			end
		endcase
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < AXES; k++) begin
				stg_pos_q[k] <= '0;
				stg_vel_q[k] <= '0;
				stg_acc_q[k] <= '0;
				stg_min_q[k] <= '0;
				stg_max_q[k] <= '0;
				act_pos_q[k] <= '0;
				act_vel_q[k] <= '0;
				act_min_q[k] <= '0;
				act_max_q[k] <= '0;
			end
			dur_q       <= '0;
			elapsed_q   <= '0;
			running_q   <= 1'b0;
			idx_q       <= '0;
			mstep_q     <= M_U2;
			st_q        <= jssp_pkg::ST_OK;
			single_q    <= 1'b1;
			any_out_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				jssp_pkg::B_DECODE: begin
					idx_q     <= '0;
					any_out_q <= 1'b0;
					single_q  <= 1'b1;
					unique case (cmd_q.kind)
						jssp_pkg::K_LOAD: begin
							st_q              <= jssp_pkg::ST_OK;
							stg_pos_q[ld_idx] <= cmd_q.position;
							stg_vel_q[ld_idx] <= cmd_q.velocity;
							stg_acc_q[ld_idx] <= cmd_q.accel_limit;
							stg_min_q[ld_idx] <= cmd_q.pos_min;
							stg_max_q[ld_idx] <= cmd_q.pos_max;
						end
						jssp_pkg::K_BAD: begin
							st_q <= jssp_pkg::ST_INVALID;
						end
						jssp_pkg::K_START: begin
							st_q <= jssp_pkg::ST_OK;
						end
						jssp_pkg::K_STEP: begin
							if (running_q) begin
								single_q  <= 1'b0;
								elapsed_q <= e_clamp;
								running_q <= e_sum < {1'b0, dur_q};
							end else begin
								st_q <= jssp_pkg::ST_NOT_READY;
							end
						end
					endcase
				end
				jssp_pkg::B_CHK: begin
					if (chk_fail) begin
						st_q <= jssp_pkg::ST_INVALID;
					end else begin
						idx_q <= is_last ? '0 : idx_q + 1'b1;
					end
				end
				jssp_pkg::B_RWAIT: begin
					if (!div_busy) begin
						idx_q <= is_last ? '0 : idx_q + 1'b1;
					end
				end
				jssp_pkg::B_ECHK: begin
					if (!end_ok) begin
						st_q <= jssp_pkg::ST_LIMIT;
					end else if (is_last) begin
						// every axis passed: commit the staged set
						for (int k = 0; k < AXES; k++) begin
							act_pos_q[k] <= stg_pos_q[k];
							act_vel_q[k] <= stg_vel_q[k];
							act_min_q[k] <= stg_min_q[k];
							act_max_q[k] <= stg_max_q[k];
						end
						dur_q     <= dacc_q;
						elapsed_q <= '0;
						running_q <= 1'b1;
						st_q      <= jssp_pkg::ST_OK;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				jssp_pkg::B_UWAIT: begin
					if (!div_busy) begin
						idx_q   <= '0;
						mstep_q <= M_U2;
					end
				end
				jssp_pkg::B_MWB: begin
					mstep_q <= mstep_q + 1'b1;
				end
				jssp_pkg::B_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if (!single_q) begin
							any_out_q <= any_out_q || !pos_ok;
							mstep_q   <= M_T;
							if (!is_last) begin
								idx_q <= idx_q + 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == jssp_pkg::B_EMIT && slot_free) begin
			res_q <= res_d;
		end
		unique case (state_q)
			jssp_pkg::B_DECODE: begin
				dacc_q <= jssp_pkg::MIN_DUR;
			end
			jssp_pkg::B_RWAIT: begin
				if (!div_busy && ratio > dacc_q) begin
					dacc_q <= ratio;
				end
			end
			jssp_pkg::B_UWAIT: begin
				u_q <= div_quo[30:0];
				w_q <= jssp_pkg::ONE_Q30 - div_quo[30:0];
			end
			jssp_pkg::B_MWB: begin
				unique case (mstep_q)
					M_U2:  u2_q <= prod_q[60:30];
					M_U3:  u3_q <= prod_q[60:30];
					M_U4:  u4_q <= prod_q[60:30];
					M_W2:  w2_q <= prod_q[60:30];
					M_V:   v_q  <= prod_q[60:30];
					M_UW: begin
						uw_q <= prod_q[60:30];
						p_q  <= u_q - u3_q + {1'b0, u4_q[30:1]};
					end
					M_T:   t_q   <= prod_q[63:16];
					M_OHI: off_q <= prod_q;
					M_OLO: off_q <= off_q + {30'd0, prod_q[63:30]};
					M_VEL: begin
						vmag_q <= prod_q[63:30];
						pos_q  <= sx64(act_pos_q[idx_q]) + (act_neg ? (64'd0 - off_q) : off_q);
					end
					M_ACC: adv_q <= {prod_q[61:0], 2'b00} + {prod_q[62:0], 1'b0};
					default: begin
					end
				endcase
			end
			jssp_pkg::B_AWAIT: begin
				amag_q <= div_quo;
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/joint_soft_stop_profile_unit.sv =====
`default_nettype none
// multi-axis soft stop generator, q16.16. start and step items both run their
// divisions on the shared restoring divider, which retires one quotient bit a
// cycle: one ratio per axis at start, one phase division plus one acceleration
// division per axis on a step. a two-entry command queue lets the input side
// keep taking transfers while results wait at the output register.
module joint_soft_stop_profile_unit #(
	parameter int AXES = jssp_pkg::AXES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic [2:0]         axis,
	input  wire logic signed [31:0] position,
	input  wire logic signed [31:0] velocity,
	input  wire logic [30:0]        accel_limit,
	input  wire logic signed [31:0] pos_min,
	input  wire logic signed [31:0] pos_max,
	input  wire logic [30:0]        dt,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [2:0]              axis_out,
	output logic signed [31:0]      position_out,
	output logic signed [31:0]      velocity_out,
	output logic signed [31:0]      accel_out,
	output logic [1:0]              vector_status,
	output logic                    last,
	output logic                    still_active
);

	jssp_pkg::cmd_t push_cmd;
	jssp_pkg::cmd_t pop_cmd;
	jssp_pkg::res_t res;
	logic           q_full;
	logic           q_push;
	logic           q_empty;
	logic           q_pop;

	jssp_front #(
		.AXES (AXES)
	) u_front (
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.axis        (axis),
		.position    (position),
		.velocity    (velocity),
		.accel_limit (accel_limit),
		.pos_min     (pos_min),
		.pos_max     (pos_max),
		.dt          (dt),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (push_cmd)
	);

	jssp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (push_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rd_cmd (pop_cmd)
	);

	jssp_back #(
		.AXES (AXES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	assign status        = res.status;
	assign axis_out      = res.axis_out;
	assign position_out  = res.position_out;
	assign velocity_out  = res.velocity_out;
	assign accel_out     = res.accel_out;
	assign vector_status = res.vector_status;
	assign last          = res.last;
	assign still_active  = res.still_active;

endmodule
`default_nettype wire

// ===== rtl/jssp_checker.sv =====
`default_nettype none
module jssp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  op,
	input wire logic [2:0]  axis,
	input wire logic [31:0] position,
	input wire logic [31:0] velocity,
	input wire logic [30:0] accel_limit,
	input wire logic [31:0] pos_min,
	input wire logic [31:0] pos_max,
	input wire logic [30:0] dt,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  status,
	input wire logic [2:0]  axis_out,
	input wire logic [31:0] position_out,
	input wire logic [31:0] velocity_out,
	input wire logic [31:0] accel_out,
	input wire logic [1:0]  vector_status,
	input wire logic        last,
	input wire logic        still_active
);

	// a stalled result transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(axis_out)
			&& $stable(position_out) && $stable(last))
		else $error("result changed while stalled");

	// only per-axis step results come without last, and they carry a bound check
	a_mid_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> (status == jssp_pkg::ST_OK || status == jssp_pkg::ST_LIMIT)
			&& vector_status == jssp_pkg::ST_OK)
		else $error("non-final result with wrong status");

	// a step refused for lack of a running stop reports nothing running
	a_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == jssp_pkg::ST_NOT_READY |-> last && !still_active
			&& position_out == '0)
		else $error("not-ready result malformed");

	// rejected items give one bare result
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == jssp_pkg::ST_INVALID |-> last && axis_out == '0
			&& velocity_out == '0 && accel_out == '0)
		else $error("invalid-argument result malformed");

endmodule

bind joint_soft_stop_profile_unit jssp_checker u_chk (.*);
`default_nettype wire
